// ===== rtl/lru_page_tag_cache_top_macros.svh =====
// Assertion macros for the LRU page tag cache checker.
`ifndef LRU_PAGE_TAG_CACHE_TOP_MACROS_SVH
`define LRU_PAGE_TAG_CACHE_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LPTC_ASSERT_NOW(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("lptc assertion failed");

// Next-cycle implication, disabled in reset.
`define LPTC_ASSERT_NEXT(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("lptc assertion failed");

`endif

// ===== rtl/lptc_pkg.sv =====
// Shared constants and types for the LRU page tag cache.
`default_nettype none
package lptc_pkg;
  localparam int MAX_ENTRIES = 32;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 6;
  localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int POS_W       = 5;
  localparam int EVOFF_W     = 32;
  localparam int OUT_W       = ((POS_W + EVOFF_W + 7) / 8) * 8;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic cmp_en;    // capture compare result this cycle
    logic valid;     // entry lies below the fill count
    logic shift_en;  // load from neighbor (or key for the head)
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/lru_page_tag_cache_top.sv =====
// Top level of the LRU page tag cache: control sequencer and row of tag cells.
// Each request passes four steps: accept, cell compare, priority search, shift/result.
// A new request waits until the previous one leaves the shared compare/search/shift loop.
// The result register frees the input side; a full result register holds the shift step.
// Synchronous active-high rst empties the list and sets capacity to 32; tags are not cleared.
`default_nettype none
module lru_page_tag_cache_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [lptc_pkg::CAP_W-1:0]  cfg_wdata,   // capacity
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [31:0]                 s_tdata,     // [31:0] page_offset
  input  wire logic [0:0]                  s_tuser,     // [0] opcode
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [lptc_pkg::OUT_W-1:0]       m_tdata,     // [4:0] hit_position, [36:5] evicted_offset
  output logic [1:0]                       m_tuser      // [0] hit, [1] evicted
);
  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_SRCH, ST_SHIFT} state_t;

  localparam int N  = lptc_pkg::MAX_ENTRIES;
  localparam int OB = lptc_pkg::OFFSET_BITS;

  state_t                          state;
  logic [lptc_pkg::CAP_W-1:0]      capacity;
  logic [lptc_pkg::CNT_W-1:0]      count;
  logic [lptc_pkg::CNT_W-1:0]      count_next;
  logic                            op;
  logic [OB-1:0]                   key;
  logic [lptc_pkg::IDX_W-1:0]      limit;
  logic                            res_hit;
  logic [lptc_pkg::IDX_W-1:0]      res_pos;
  logic                            res_ev;
  logic [lptc_pkg::EVOFF_W-1:0]    res_evoff;
  logic                            out_hit;
  logic [lptc_pkg::POS_W-1:0]      out_pos;
  logic                            out_ev;
  logic [lptc_pkg::EVOFF_W-1:0]    out_evoff;

  logic [OB-1:0]                   entries [N];
  logic [N-1:0]                    match_vec;
  lptc_pkg::cell_ctrl_t            cell_ctrl [N];
  logic                            found;
  logic [lptc_pkg::IDX_W-1:0]      found_pos;
  logic [lptc_pkg::CMP_W-1:0]      cap_ext;
  logic [lptc_pkg::CNT_W-1:0]      eff_cap;
  logic                            ev_now;
  logic [lptc_pkg::CNT_W-1:0]      cnt_after;
  logic [lptc_pkg::CNT_W-1:0]      cnt_m1;
  logic                            out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Row of cells; cell 0 loads the key, others take from the cell above.
  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].cmp_en   = (state == ST_CMP);
      cell_ctrl[i].valid    = (lptc_pkg::CNT_W'(i) < count);
      cell_ctrl[i].shift_en = (state == ST_SHIFT) && out_free &&
                              (lptc_pkg::IDX_W'(i) <= limit);
    end
    if (i == 0) begin : g_head
      lptc_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[i]),
        .key      (key),
        .shift_in (key),
        .entry    (entries[i]),
        .match    (match_vec[i])
      );
    end else begin : g_body
      lptc_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[i]),
        .key      (key),
        .shift_in (entries[i-1]),
        .entry    (entries[i]),
        .match    (match_vec[i])
      );
    end
  end

  lptc_prio u_prio (
    .match_vec (match_vec),
    .found     (found),
    .pos       (found_pos)
  );

  // Capacity clamped to [2, MAX_ENTRIES].
  always_comb begin
    cap_ext = lptc_pkg::CMP_W'(capacity);
    if (cap_ext < lptc_pkg::CMP_W'(2)) begin
      eff_cap = lptc_pkg::CNT_W'(2);
    end else if (cap_ext > lptc_pkg::CMP_W'(N)) begin
      eff_cap = lptc_pkg::CNT_W'(N);
    end else begin
      eff_cap = lptc_pkg::CNT_W'(cap_ext);
    end
  end

  always_comb begin
    ev_now    = !(found && (op == lptc_pkg::OP_LOOKUP)) && (count >= eff_cap);
    cnt_after = count - lptc_pkg::CNT_W'(ev_now);
    cnt_m1    = count - lptc_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lptc_pkg::CAP_W'(32);
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_SHIFT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser[0];
            key   <= OB'(s_tdata);
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_SRCH;
        end
        ST_SRCH: begin
          res_hit   <= found && (op == lptc_pkg::OP_LOOKUP);
          res_pos   <= (found && (op == lptc_pkg::OP_LOOKUP)) ? found_pos : '0;
          res_ev    <= ev_now;
          res_evoff <= ev_now ? lptc_pkg::EVOFF_W'(entries[cnt_m1[lptc_pkg::IDX_W-1:0]])
                              : '0;
          if (found && (op == lptc_pkg::OP_LOOKUP)) begin
            limit      <= found_pos;
            count_next <= count;
          end else begin
            // Miss or insert: in this branch cnt_after never exceeds MAX_ENTRIES-1.
            limit      <= cnt_after[lptc_pkg::IDX_W-1:0];
            count_next <= cnt_after + lptc_pkg::CNT_W'(1);
          end
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (out_free) begin
            count     <= count_next;
            out_hit   <= res_hit;
            out_pos   <= lptc_pkg::POS_W'(res_pos);
            out_ev    <= res_ev;
            out_evoff <= res_evoff;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = lptc_pkg::OUT_W'({out_evoff, out_pos});
  assign m_tuser = {out_ev, out_hit};
endmodule
`default_nettype wire

// ===== rtl/lptc_cell.sv =====
// One tag cell: holds an entry, compares it to the key, shifts from its neighbor.
`default_nettype none
module lptc_cell (
  input  wire logic                             clk,
  input  wire lptc_pkg::cell_ctrl_t             ctrl,
  input  wire logic [lptc_pkg::OFFSET_BITS-1:0] key,
  input  wire logic [lptc_pkg::OFFSET_BITS-1:0] shift_in,
  output logic      [lptc_pkg::OFFSET_BITS-1:0] entry,
  output logic                                  match
);
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= ctrl.valid && (entry == key);
    end
    if (ctrl.shift_en) begin
      entry <= shift_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lptc_prio.sv =====
// Priority encoder: lowest matching cell wins (most recent duplicate).
`default_nettype none
module lptc_prio (
  input  wire logic [lptc_pkg::MAX_ENTRIES-1:0] match_vec,
  output logic                                  found,
  output logic      [lptc_pkg::IDX_W-1:0]       pos
);
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = lptc_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        found = 1'b1;
        pos   = lptc_pkg::IDX_W'(i);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lptc_checker.sv =====
// Port-level checker for the LRU page tag cache, bound to the top level.
`default_nettype none
`include "lru_page_tag_cache_top_macros.svh"
module lptc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [lptc_pkg::OUT_W-1:0]    m_tdata,
  input wire logic [1:0]                    m_tuser
);
  `LPTC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `LPTC_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)
  `LPTC_ASSERT_NOW(a_hit_no_evict, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  `LPTC_ASSERT_NOW(a_evoff_zero, clk, rst, m_tvalid && !m_tuser[1], m_tdata[36:5] == 32'd0)
  `LPTC_ASSERT_NOW(a_pos_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[4:0] == 5'd0)
endmodule

bind lru_page_tag_cache_top lptc_checker u_lptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
